>>> sv/sps_pkg.sv
// ----------------------------------------------------------------------------
// Spin profile sequencer package
// Shared widths, codes, the step entry layout and the S-curve table.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int MAX_STEPS      = 16;
	localparam int STEP_AW        = $clog2(MAX_STEPS);
	localparam int COS_TABLE_SIZE = 256;
	localparam int COS_AW         = $clog2(COS_TABLE_SIZE);
	localparam int FRAC_W         = 16;
	localparam int RPM_W          = 15;
	localparam int MS_W           = 20;
	localparam int EL_W           = 21;

	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_LOAD   = 3'd1;
	localparam logic [2:0] CMD_RUN    = 3'd2;
	localparam logic [2:0] CMD_STOP   = 3'd3;
	localparam logic [2:0] CMD_PAUSE  = 3'd4;
	localparam logic [2:0] CMD_RESUME = 3'd5;
	localparam logic [2:0] CMD_MANUAL = 3'd6;
	localparam logic [2:0] CMD_SETRPM = 3'd7;

	localparam logic [2:0] MODE_IDLE     = 3'd0;
	localparam logic [2:0] MODE_RUN      = 3'd1;
	localparam logic [2:0] MODE_PAUSE    = 3'd2;
	localparam logic [2:0] MODE_STOPPING = 3'd3;
	localparam logic [2:0] MODE_MANUAL   = 3'd4;
	localparam logic [2:0] MODE_ESTOP    = 3'd5;

	localparam logic [1:0] KIND_LINEAR  = 2'd0;
	localparam logic [1:0] KIND_SQUARED = 2'd1;
	localparam logic [1:0] KIND_SCURVE  = 2'd2;
	localparam logic [1:0] KIND_BUTTON  = 2'd3;

	localparam logic       REG_STEPS  = 1'b0;
	localparam logic       REG_THRESH = 1'b1;

	typedef struct packed {
		logic [1:0]       kind;
		logic [MS_W-1:0]  ramp;
		logic [MS_W-1:0]  hold;
		logic [RPM_W-1:0] target;
	} step_entry_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [MS_W-1:0]  elapsed;
		logic [MS_W-1:0]  ramp;
		logic [RPM_W-1:0] start_rpm;
		logic [RPM_W-1:0] target;
	} ramp_req_t;

	typedef logic [FRAC_W:0] scurve_tab_t [0:COS_TABLE_SIZE];

	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint unsigned SinDiv [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
	localparam longint unsigned HalfSteps = 2 * COS_TABLE_SIZE;

	function automatic scurve_tab_t build_scurve();
		scurve_tab_t      tab;
		longint unsigned  y;
		longint unsigned  x2;
		longint unsigned  term;
		longint unsigned  s;
		longint unsigned  sq;
		longint unsigned  v;
		longint           sum;
		for (int k = 0; k <= COS_TABLE_SIZE; k++) begin
			y    = (PI_Q30 * longint'(k)) / HalfSteps;
			x2   = (y * y) >> 30;
			term = y;
			sum  = longint'(y);
			for (int n = 1; n <= 6; n++) begin
				term = (term * x2) >> 30;
				term = term / SinDiv[n];
				if (n % 2 == 1) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			if (sum < 0) sum = 0;
			s  = longint'(sum);
			sq = (s * s) >> 30;
			v  = (sq + 64'd8192) >> 14;
			if (v > 64'd65536) v = 64'd65536;
			tab[k] = v[FRAC_W:0];
		end
		return tab;
	endfunction

	localparam scurve_tab_t SCURVE_TAB = build_scurve();

endpackage

>>> sv/sps_step_ram.sv
// ----------------------------------------------------------------------------
// Step table memory
// One write port and one registered read port holding the profile steps.
// ----------------------------------------------------------------------------
module sps_step_ram (
	input  logic                          clk,
	input  logic                          we,
	input  logic [sps_pkg::STEP_AW-1:0]   waddr,
	input  sps_pkg::step_entry_t          wdata,
	input  logic [sps_pkg::STEP_AW-1:0]   raddr,
	output sps_pkg::step_entry_t          rdata
);
	import sps_pkg::*;

	step_entry_t mem [0:MAX_STEPS-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/sps_ramp_unit.sv
// ----------------------------------------------------------------------------
// Ramp setpoint unit
// Serial divider for the ramp fraction, shape multiply and final blend.
// ----------------------------------------------------------------------------
module sps_ramp_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  sps_pkg::ramp_req_t       req,
	output logic                     done,
	output logic [sps_pkg::RPM_W-1:0] setpoint
);
	import sps_pkg::*;

	typedef enum logic [2:0] {R_IDLE, R_DIV, R_MUL1, R_MUL2, R_ACC} rstate_t;

	rstate_t                  state_q;
	ramp_req_t                req_q;
	logic [MS_W-1:0]          rem_q;
	logic [FRAC_W-1:0]        frac_q;
	logic [$clog2(FRAC_W)-1:0] cnt_q;
	logic [31:0]              prod1_q;
	logic [FRAC_W:0]          base_q;
	logic signed [34:0]       prod2_q;

	logic [MS_W:0]            trial;
	logic [COS_AW-1:0]        idx;
	logic [FRAC_W:0]          tab_a;
	logic [FRAC_W:0]          tab_b;
	logic [FRAC_W:0]          tab_d;
	logic [FRAC_W-COS_AW-1:0] tab_r;
	logic [FRAC_W:0]          shape;
	logic signed [RPM_W:0]    delta;
	logic signed [35:0]       acc;

	assign trial = {rem_q, 1'b0};
	assign idx   = frac_q[FRAC_W-1 -: COS_AW];
	assign tab_r = frac_q[FRAC_W-COS_AW-1:0];
	assign tab_a = SCURVE_TAB[idx];
	assign tab_b = SCURVE_TAB[{1'b0, idx} + 9'd1];
	assign tab_d = (tab_b >= tab_a) ? tab_b - tab_a : '0;
	assign delta = $signed({1'b0, req_q.target}) - $signed({1'b0, req_q.start_rpm});

	always_comb begin
		case (req_q.kind)
			KIND_SQUARED: shape = {1'b0, prod1_q[31:16]};
			KIND_SCURVE:  shape = base_q + prod1_q[FRAC_W+FRAC_W-COS_AW:FRAC_W-COS_AW];
			default:      shape = {1'b0, frac_q};
		endcase
	end

	assign acc      = $signed({5'b0, req_q.start_rpm, 16'b0}) + 36'(prod2_q);
	assign setpoint = acc[35] ? '0 : acc[RPM_W+15:16];
	assign done     = (state_q == R_ACC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
		end else begin
			case (state_q)
				R_IDLE: begin
					if (go) begin
						req_q   <= req;
						rem_q   <= req.elapsed;
						cnt_q   <= '0;
						state_q <= R_DIV;
					end
				end
				R_DIV: begin
					if (trial >= {1'b0, req_q.ramp}) begin
						rem_q  <= MS_W'(trial - {1'b0, req_q.ramp});
						frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
					end else begin
						rem_q  <= trial[MS_W-1:0];
						frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) state_q <= R_MUL1;
				end
				R_MUL1: begin
					if (req_q.kind == KIND_SCURVE) begin
						prod1_q <= 32'(tab_d * tab_r);
					end else begin
						prod1_q <= frac_q * frac_q;
					end
					base_q  <= tab_a;
					state_q <= R_MUL2;
				end
				R_MUL2: begin
					prod2_q <= 35'(delta * $signed({1'b0, shape}));
					state_q <= R_ACC;
				end
				R_ACC: begin
					state_q <= R_IDLE;
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

endmodule

>>> sv/spin_profile_setpoint_sequencer_core.sv
// ----------------------------------------------------------------------------
// Spin profile setpoint sequencer
// Runs a ramp and hold speed profile from a step table, one word per command.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; the command
// field selects tick, load step, run, stop, pause, resume, manual or manual
// rpm. Exactly one result word follows for every command: it is shown on the
// result ports for one cycle with done high. The receiver cannot hold results
// off and the block never waits for it.
// A non-ramp command steps through the read, execute, second read and finish
// states, with a table write first for load step. A tick that computes a ramp
// point adds the ramp unit: a serial divider for the ramp fraction and two
// multiply stages. The step table is a synchronous memory with one write port
// and one read port; every command reads the active step and reads it again.
// Configuration writes on cfg_we are taken at once; they are to be made
// only while no command is in flight.
// Reset clears the mode to idle, the pointers and setpoints to zero, the
// step count to zero and the stop threshold to 100 rpm. The step table is
// not cleared; each step must be loaded before a profile uses it.
// ----------------------------------------------------------------------------
module spin_profile_setpoint_sequencer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                command,
	input  logic [3:0]                step_slot,
	input  logic [1:0]                ramp_kind,
	input  logic [19:0]               ramp_ms,
	input  logic [19:0]               hold_ms,
	input  logic [14:0]               rpm_value,
	input  logic [15:0]               measured_rpm,
	input  logic                      safety_fault,
	input  logic                      start_button,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [15:0]               cfg_data,
	output logic                      done,
	output logic [14:0]               target_rpm,
	output logic                      motor_drive,
	output logic [2:0]                mode,
	output logic [3:0]                active_step,
	output logic [20:0]               step_ms_left,
	output logic                      accepted
);
	import sps_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_WR, S_RD, S_EXEC, S_RAMP, S_RD2, S_FIN} state_t;

	state_t             state_q;
	logic [2:0]         cmd_q;
	logic [3:0]         slot_q;
	logic [1:0]         kind_q;
	logic [MS_W-1:0]    ramp_q;
	logic [MS_W-1:0]    hold_q;
	logic [RPM_W-1:0]   rpm_q;
	logic [15:0]        meas_q;
	logic               fault_q;
	logic               button_q;

	logic [4:0]         steps_q;
	logic [15:0]        thresh_q;
	logic [2:0]         mode_q;
	logic [STEP_AW-1:0] ptr_q;
	logic [EL_W-1:0]    elapsed_q;
	logic [RPM_W-1:0]   start_rpm_q;
	logic [RPM_W-1:0]   setpoint_q;
	logic [RPM_W-1:0]   manual_q;
	logic               bwp_q;
	logic               acc_q;

	step_entry_t        wr_entry;
	step_entry_t        entry;
	ramp_req_t          rreq;
	logic               ramp_go;
	logic               ramp_done;
	logic [RPM_W-1:0]   ramp_sp;
	logic [4:0]         count;
	logic               last_step;
	logic [EL_W-1:0]    total;
	logic               slot_ok;
	logic [EL_W-1:0]    el_inc;
	logic               cmd_ok;

	assign wr_entry = '{kind: kind_q, ramp: ramp_q, hold: hold_q, target: rpm_q};

	sps_step_ram u_ram (
		.clk   (clk),
		.we    (state_q == S_WR),
		.waddr (slot_q[STEP_AW-1:0]),
		.wdata (wr_entry),
		.raddr (ptr_q),
		.rdata (entry)
	);

	assign rreq    = '{kind: entry.kind, elapsed: elapsed_q[MS_W-1:0], ramp: entry.ramp,
			start_rpm: start_rpm_q, target: entry.target};
	assign ramp_go = (state_q == S_EXEC) && (cmd_q == CMD_TICK) && (mode_q == MODE_RUN)
			&& !(fault_q) && (entry.kind != KIND_BUTTON)
			&& (elapsed_q < {1'b0, entry.ramp});

	sps_ramp_unit u_ramp (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (ramp_go),
		.req      (rreq),
		.done     (ramp_done),
		.setpoint (ramp_sp)
	);

	assign count     = (steps_q > 5'(MAX_STEPS)) ? 5'(MAX_STEPS) : steps_q;
	assign last_step = ({1'b0, ptr_q} + 5'd1) >= count;
	assign total     = {1'b0, entry.ramp} + {1'b0, entry.hold};
	assign slot_ok   = {1'b0, slot_q} < 5'(MAX_STEPS);
	assign busy      = (state_q != S_IDLE);
	assign el_inc    = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;

	always_comb begin
		case (cmd_q)
			CMD_LOAD:   cmd_ok = slot_ok;
			CMD_PAUSE:  cmd_ok = (mode_q == MODE_RUN);
			CMD_RESUME: cmd_ok = (mode_q == MODE_PAUSE);
			CMD_SETRPM: cmd_ok = (mode_q == MODE_MANUAL);
			default:    cmd_ok = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			steps_q     <= '0;
			thresh_q    <= 16'd100;
			mode_q      <= MODE_IDLE;
			ptr_q       <= '0;
			elapsed_q   <= '0;
			start_rpm_q <= '0;
			setpoint_q  <= '0;
			manual_q    <= '0;
			bwp_q       <= 1'b0;
			acc_q       <= 1'b0;
			done        <= 1'b0;
		end else begin
			done <= (state_q == S_FIN);
			if (cfg_we) begin
				case (cfg_index)
					REG_STEPS:  steps_q  <= cfg_data[4:0];
					REG_THRESH: thresh_q <= cfg_data;
					default:    ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q    <= command;
						slot_q   <= step_slot;
						kind_q   <= ramp_kind;
						ramp_q   <= ramp_ms;
						hold_q   <= hold_ms;
						rpm_q    <= rpm_value;
						meas_q   <= measured_rpm;
						fault_q  <= safety_fault;
						button_q <= start_button;
						state_q  <= (command == CMD_LOAD) ? S_WR : S_RD;
					end
				end
				S_WR: state_q <= S_RD;
				S_RD: state_q <= S_EXEC;
				S_EXEC: begin
					acc_q   <= cmd_ok;
					state_q <= ramp_go ? S_RAMP : S_RD2;
					case (cmd_q)
						CMD_TICK: begin
							if (fault_q && mode_q != MODE_IDLE && mode_q != MODE_ESTOP) begin
								mode_q <= MODE_ESTOP;
							end else if (mode_q == MODE_RUN) begin
								if (entry.kind == KIND_BUTTON) begin
									setpoint_q <= '0;
									bwp_q      <= button_q;
									if (button_q && !bwp_q && !last_step) begin
										ptr_q       <= ptr_q + 1'b1;
										start_rpm_q <= entry.target;
										elapsed_q   <= '0;
									end else begin
										elapsed_q <= el_inc;
										if (button_q && !bwp_q) mode_q <= MODE_STOPPING;
									end
								end else if (elapsed_q < {1'b0, entry.ramp}) begin
									elapsed_q <= el_inc;
								end else if (elapsed_q < total) begin
									elapsed_q  <= el_inc;
									setpoint_q <= entry.target;
								end else if (last_step) begin
									elapsed_q <= el_inc;
									mode_q    <= MODE_STOPPING;
								end else begin
									ptr_q       <= ptr_q + 1'b1;
									start_rpm_q <= entry.target;
									elapsed_q   <= '0;
								end
							end else if (mode_q == MODE_STOPPING) begin
								if (meas_q < thresh_q) mode_q <= MODE_IDLE;
							end else if (mode_q == MODE_MANUAL) begin
								setpoint_q <= manual_q;
							end
						end
						CMD_LOAD: ;
						CMD_RUN: begin
							ptr_q       <= '0;
							elapsed_q   <= '0;
							start_rpm_q <= meas_q[15] ? '1 : meas_q[RPM_W-1:0];
							setpoint_q  <= '0;
							mode_q      <= (count == '0) ? MODE_STOPPING : MODE_RUN;
						end
						CMD_STOP: mode_q <= MODE_STOPPING;
						CMD_PAUSE: begin
							if (mode_q == MODE_RUN) mode_q <= MODE_PAUSE;
						end
						CMD_RESUME: begin
							if (mode_q == MODE_PAUSE) mode_q <= MODE_RUN;
						end
						CMD_MANUAL: begin
							mode_q   <= MODE_MANUAL;
							manual_q <= '0;
						end
						default: begin
							if (mode_q == MODE_MANUAL) manual_q <= rpm_q;
						end
					endcase
				end
				S_RAMP: begin
					if (ramp_done) begin
						setpoint_q <= ramp_sp;
						state_q    <= S_RD2;
					end
				end
				S_RD2: state_q <= S_FIN;
				S_FIN: begin
					target_rpm   <= setpoint_q;
					motor_drive  <= (mode_q == MODE_RUN) || (mode_q == MODE_PAUSE)
							|| (mode_q == MODE_MANUAL);
					mode         <= mode_q;
					active_step  <= 4'(ptr_q);
					step_ms_left <= (mode_q == MODE_RUN && total > elapsed_q)
							? total - elapsed_q : '0;
					accepted     <= acc_q;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> dv/sps_profile_checker.sv
// ----------------------------------------------------------------------------
// Spin profile sequencer checker
// Watches the command, configuration and result ports of the sequencer,
// predicts every result word from its own copy of the profile state and
// compares each one, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sps_profile_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  command,
	input  logic [3:0]  step_slot,
	input  logic [1:0]  ramp_kind,
	input  logic [19:0] ramp_ms,
	input  logic [19:0] hold_ms,
	input  logic [14:0] rpm_value,
	input  logic [15:0] measured_rpm,
	input  logic        safety_fault,
	input  logic        start_button,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        done,
	input  logic [14:0] target_rpm,
	input  logic        motor_drive,
	input  logic [2:0]  mode,
	input  logic [3:0]  active_step,
	input  logic [20:0] step_ms_left,
	input  logic        accepted,
	output int          pending,
	output int          fail_count,
	output logic [2:0]  model_mode
);
	import sps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [14:0] target_rpm;
		logic        motor_drive;
		logic [2:0]  mode;
		logic [3:0]  active_step;
		logic [20:0] step_ms_left;
		logic        accepted;
	} status_word_t;

	status_word_t status_fifo[$];

	logic [1:0]  prof_kind   [MAX_STEPS];
	logic [19:0] prof_ramp   [MAX_STEPS];
	logic [19:0] prof_hold   [MAX_STEPS];
	logic [14:0] prof_target [MAX_STEPS];
	logic [2:0]  run_state;
	logic [3:0]  cur_step;
	logic [20:0] ms_in_step;
	logic [14:0] ramp_origin;
	logic [14:0] cur_setpoint;
	logic [14:0] hand_setpoint;
	logic        button_prev;
	logic [4:0]  loaded_steps;
	logic [15:0] idle_threshold;
	longint unsigned scurve [0:COS_TABLE_SIZE];

	assign pending    = status_fifo.size();
	assign model_mode = run_state;

	function automatic longint unsigned series_sine(longint unsigned ang);
		longint unsigned sq;
		longint unsigned t;
		longint          acc;
		sq  = (ang * ang) >> 30;
		t   = ang;
		acc = longint'(ang);
		for (int n = 1; n <= 6; n++) begin
			t = ((t * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
			acc = (n % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
		end
		return (acc < 0) ? 0 : longint'(acc);
	endfunction

	initial begin
		longint unsigned s;
		longint unsigned v;
		for (int k = 0; k <= COS_TABLE_SIZE; k++) begin
			s = series_sine((64'd3373259426 * longint'(k)) / (2 * COS_TABLE_SIZE));
			v = (((s * s) >> 30) + 64'd8192) >> 14;
			scurve[k] = (v > 64'd65536) ? 64'd65536 : v;
		end
	end

	function automatic logic [14:0] ramp_point(int unsigned idx, logic [20:0] el);
		longint unsigned frac;
		longint unsigned shape;
		longint unsigned p;
		longint unsigned lo;
		longint unsigned hi;
		longint          acc;
		frac = (longint'(el) << 16) / longint'(prof_ramp[idx]);
		if (frac > 65536) frac = 65536;
		case (prof_kind[idx])
			KIND_SQUARED: begin
				shape = (frac * frac) >> 16;
			end
			KIND_SCURVE: begin
				p = frac * COS_TABLE_SIZE;
				if ((p >> 16) >= COS_TABLE_SIZE) begin
					shape = scurve[COS_TABLE_SIZE];
				end else begin
					lo = scurve[p >> 16];
					hi = scurve[(p >> 16) + 1];
					shape = lo + ((((hi >= lo) ? hi - lo : 0) * (p & 16'hFFFF)) >> 16);
				end
			end
			default: begin
				shape = frac;
			end
		endcase
		acc = longint'(ramp_origin) * 65536 +
			(longint'(prof_target[idx]) - longint'(ramp_origin)) * longint'(shape);
		if (acc < 0) acc = 0;
		return 15'((acc >> 16) & 16'h7FFF);
	endfunction

	function automatic void advance_step();
		int unsigned count;
		count = (loaded_steps > MAX_STEPS) ? MAX_STEPS : loaded_steps;
		if (cur_step + 1 >= count) begin
			run_state = MODE_STOPPING;
		end else begin
			ramp_origin = prof_target[cur_step];
			cur_step    = cur_step + 1;
			ms_in_step  = '0;
		end
	endfunction

	function automatic void on_tick();
		logic [20:0] el;
		if (safety_fault && run_state != MODE_IDLE && run_state != MODE_ESTOP)
			run_state = MODE_ESTOP;
		if (run_state == MODE_RUN) begin
			el = ms_in_step;
			if (ms_in_step != 21'h1FFFFF) ms_in_step = ms_in_step + 1;
			if (prof_kind[cur_step] == KIND_BUTTON) begin
				cur_setpoint = '0;
				if (start_button && !button_prev) advance_step();
				button_prev = start_button;
			end else if (el < prof_ramp[cur_step]) begin
				cur_setpoint = ramp_point(cur_step, el);
			end else if (el < 21'(prof_ramp[cur_step]) + 21'(prof_hold[cur_step])) begin
				cur_setpoint = prof_target[cur_step];
			end else begin
				advance_step();
			end
		end else if (run_state == MODE_STOPPING) begin
			if (measured_rpm < idle_threshold) run_state = MODE_IDLE;
		end else if (run_state == MODE_MANUAL) begin
			cur_setpoint = hand_setpoint;
		end
	endfunction

	function automatic status_word_t predict_status();
		status_word_t w;
		logic [20:0]  total;
		w.accepted = 1'b1;
		case (command)
			CMD_TICK: on_tick();
			CMD_LOAD: begin
				prof_kind[step_slot]   = ramp_kind;
				prof_ramp[step_slot]   = ramp_ms;
				prof_hold[step_slot]   = hold_ms;
				prof_target[step_slot] = rpm_value;
			end
			CMD_RUN: begin
				cur_step     = '0;
				ms_in_step   = '0;
				ramp_origin  = measured_rpm[15] ? 15'h7FFF : measured_rpm[14:0];
				cur_setpoint = '0;
				run_state    = (loaded_steps == 0) ? MODE_STOPPING : MODE_RUN;
			end
			CMD_STOP: run_state = MODE_STOPPING;
			CMD_PAUSE: begin
				if (run_state == MODE_RUN) run_state = MODE_PAUSE;
				else w.accepted = 1'b0;
			end
			CMD_RESUME: begin
				if (run_state == MODE_PAUSE) run_state = MODE_RUN;
				else w.accepted = 1'b0;
			end
			CMD_MANUAL: begin
				run_state     = MODE_MANUAL;
				hand_setpoint = '0;
			end
			default: begin
				if (run_state == MODE_MANUAL) hand_setpoint = rpm_value;
				else w.accepted = 1'b0;
			end
		endcase
		w.step_ms_left = '0;
		if (run_state == MODE_RUN) begin
			total = 21'(prof_ramp[cur_step]) + 21'(prof_hold[cur_step]);
			if (total > ms_in_step) w.step_ms_left = total - ms_in_step;
		end
		w.target_rpm  = cur_setpoint;
		w.motor_drive = (run_state == MODE_RUN || run_state == MODE_PAUSE ||
			run_state == MODE_MANUAL);
		w.mode        = run_state;
		w.active_step = cur_step;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		status_word_t exp_w;
		int           errs;
		if (!arst_n) begin
			status_fifo.delete();
			fail_count     <= 0;
			run_state      = MODE_IDLE;
			cur_step       = '0;
			ms_in_step     = '0;
			ramp_origin    = '0;
			cur_setpoint   = '0;
			hand_setpoint  = '0;
			button_prev    = 1'b0;
			loaded_steps   = '0;
			idle_threshold = 16'd100;
		end else begin
			errs = 0;
			if (done) begin
				if (status_fifo.size() == 0) begin
					$error("result word with no command outstanding");
					errs++;
				end else begin
					exp_w = status_fifo.pop_front();
					if (target_rpm !== exp_w.target_rpm) begin
						$error("target_rpm: expected %0d, got %0d", exp_w.target_rpm, target_rpm);
						errs++;
					end
					if (motor_drive !== exp_w.motor_drive) begin
						$error("motor_drive: expected %0d, got %0d", exp_w.motor_drive, motor_drive);
						errs++;
					end
					if (mode !== exp_w.mode) begin
						$error("mode: expected %0d, got %0d", exp_w.mode, mode);
						errs++;
					end
					if (active_step !== exp_w.active_step) begin
						$error("active_step: expected %0d, got %0d", exp_w.active_step, active_step);
						errs++;
					end
					if (step_ms_left !== exp_w.step_ms_left) begin
						$error("step_ms_left: expected %0d, got %0d", exp_w.step_ms_left,
							step_ms_left);
						errs++;
					end
					if (accepted !== exp_w.accepted) begin
						$error("accepted: expected %0d, got %0d", exp_w.accepted, accepted);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
			if (cfg_we) begin
				if (cfg_index == REG_STEPS) loaded_steps = cfg_data[4:0];
				else idle_threshold = cfg_data;
			end
			if (start && !busy) status_fifo.push_back(predict_status());
		end
	end

	final begin
		if (status_fifo.size() != 0)
			$error("%0d result words never arrived", status_fifo.size());
	end
endmodule

>>> dv/spin_profile_setpoint_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// Spin profile sequencer testbench
// Loads step tables, runs profiles through ticks, pauses, stops, faults and
// manual mode under several step counts and stop thresholds, with random
// bursts and gaps on the command side; a checker module predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module spin_profile_setpoint_sequencer_core_tb;
	import sps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  command = CMD_TICK;
	logic [3:0]  step_slot = '0;
	logic [1:0]  ramp_kind = KIND_LINEAR;
	logic [19:0] ramp_ms = '0;
	logic [19:0] hold_ms = '0;
	logic [14:0] rpm_value = '0;
	logic [15:0] measured_rpm = '0;
	logic        safety_fault = 1'b0;
	logic        start_button = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_STEPS;
	logic [15:0] cfg_data = '0;
	logic        done;
	logic [14:0] target_rpm;
	logic        motor_drive;
	logic [2:0]  mode;
	logic [3:0]  active_step;
	logic [20:0] step_ms_left;
	logic        accepted;
	int          pending;
	int          fail_count;
	logic [2:0]  model_mode;
	int          burst_left = 0;
	int          words_sent = 0;
	int          quiet_cycles = 0;

	always #10 clk = ~clk;

	spin_profile_setpoint_sequencer_core i_dut (.*);

	sps_profile_checker i_checker (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_word(logic [2:0] cmd, logic [3:0] slot, logic [1:0] kind,
		logic [19:0] ramp, logic [19:0] hold, logic [14:0] rpm, logic [15:0] meas,
		logic fault, logic button);
		if (burst_left == 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(8)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		command = cmd;
		step_slot = slot;
		ramp_kind = kind;
		ramp_ms = ramp;
		hold_ms = hold;
		rpm_value = rpm;
		measured_rpm = meas;
		safety_fault = fault;
		start_button = button;
		start = 1'b1;
		while (busy) @(negedge clk);
		@(posedge clk);
		words_sent++;
	endtask

	task automatic simple(logic [2:0] cmd, logic [15:0] meas = 0, logic [14:0] rpm = 0);
		send_word(cmd, 0, KIND_LINEAR, 0, 0, rpm, meas, 1'b0, 1'b0);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		if (model_mode != MODE_IDLE) begin
			if (model_mode != MODE_STOPPING) simple(CMD_STOP);
			while (model_mode != MODE_IDLE) simple(CMD_TICK, 16'd0);
		end
		@(negedge clk);
		start = 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_random(logic [3:0] slot);
		logic [19:0] ramp;
		logic [19:0] hold;
		ramp = ($urandom_range(99) < 3) ? 20'($urandom) : 20'($urandom_range(12));
		hold = ($urandom_range(99) < 3) ? 20'($urandom) : 20'($urandom_range(6));
		send_word(CMD_LOAD, slot, 2'($urandom), ramp, hold,
			15'($urandom_range(20000)), 16'($urandom), 1'b0, 1'b0);
	endtask

	task automatic random_word();
		logic [2:0] cmd;
		cmd = ($urandom_range(99) < 70) ? CMD_TICK : 3'($urandom_range(1, 7));
		if (cmd == CMD_LOAD) load_random(4'($urandom));
		else send_word(cmd, 4'($urandom), 2'($urandom), 20'($urandom), 20'($urandom),
			15'($urandom_range(20000)),
			($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(150)),
			($urandom_range(99) < 4), 1'($urandom));
	endtask

	initial begin
		logic [15:0] steps_pick [6];
		logic [15:0] thresh_pick [5];
		steps_pick  = '{0, 1, 2, 16, 31, 5};
		thresh_pick = '{1, 100, 65535, 50, 20};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		simple(CMD_TICK);
		send_word(CMD_LOAD, 0, KIND_LINEAR, 0, 0, 0, 16'hFFFF, 1'b1, 1'b1);
		send_word(CMD_LOAD, 1, KIND_SQUARED, 8, 3, 20000, 0, 1'b0, 1'b0);
		send_word(CMD_LOAD, 2, KIND_SCURVE, 10, 2, 5, 0, 1'b0, 1'b0);
		send_word(CMD_LOAD, 3, KIND_BUTTON, 0, 0, 16384, 0, 1'b0, 1'b0);
		send_word(CMD_LOAD, 15, KIND_LINEAR, 20'hFFFFF, 20'hFFFFF, 20000, 0, 1'b0, 1'b0);
		for (int s = 4; s < 15; s++) load_random(4'(s));
		simple(CMD_RUN, 16'd500);
		simple(CMD_TICK, 16'd200);
		simple(CMD_PAUSE);
		simple(CMD_RESUME);
		simple(CMD_SETRPM, 0, 15'd123);
		simple(CMD_MANUAL);
		simple(CMD_SETRPM, 0, 15'd20000);
		simple(CMD_TICK);
		send_word(CMD_TICK, 0, KIND_LINEAR, 0, 0, 0, 0, 1'b1, 1'b0);
		simple(CMD_STOP);

		for (int ph = 0; words_sent < 500; ph++) begin
			write_reg(REG_STEPS, (ph < 6) ? steps_pick[ph] : 16'($urandom_range(31)));
			write_reg(REG_THRESH, (ph < 5) ? thresh_pick[ph] : 16'($urandom_range(65535, 1)));
			repeat ($urandom_range(3)) load_random(4'($urandom));
			simple(CMD_RUN, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000)));
			repeat ($urandom_range(15, 40)) random_word();
		end

		write_reg(REG_THRESH, 16'd0);
		simple(CMD_RUN, 16'd0);
		repeat (10) random_word();
		simple(CMD_STOP);
		simple(CMD_TICK, 16'd0);

		@(negedge clk);
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
